### hdl/persistent_stack_with_rollback_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the persistent stack core
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef PERSISTENT_STACK_WITH_ROLLBACK_CORE_ASSERT_SVH
`define PERSISTENT_STACK_WITH_ROLLBACK_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PSWR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pswr assertion failed");

// next-cycle implication
`define PSWR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pswr assertion failed");

`else

`define PSWR_ASSERT_IMP(label, ante, cons)
`define PSWR_ASSERT_NXT(label, ante, cons)

`endif

`endif

### hdl/pswr_pkg.sv
// ---------------------------------------------------------------------------
// pswr_pkg
// Constants, types and helpers shared by the persistent stack core.
// ---------------------------------------------------------------------------
package pswr_pkg;

    localparam int MAX_OPS    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int SLOTS      = MAX_OPS + 1;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int FIELD_W    = 32;

    localparam logic signed [FIELD_W-1:0] EMPTY_TOP = -32'sd1;

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_ROLLBACK = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LINK = 1'b1
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic needs_link;
    } dp_status_t;

    // Truncate the pushed argument to the stored width, keeping its sign.
    function automatic logic [VALUE_BITS-1:0] fit_value(input logic signed [FIELD_W-1:0] arg);
        return VALUE_BITS'(arg);
    endfunction

endpackage

### hdl/pswr_op_if.sv
// ---------------------------------------------------------------------------
// pswr_op_if
// Operation channel: valid/ready handshake with operation code and argument.
// ---------------------------------------------------------------------------
interface pswr_op_if;

    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] argument;

    modport source (output valid, output operation, output argument, input ready);
    modport sink   (input valid, input operation, input argument, output ready);

endinterface

### hdl/pswr_res_if.sv
// ---------------------------------------------------------------------------
// pswr_res_if
// Result channel: valid/ready handshake with top value and overflow flag.
// ---------------------------------------------------------------------------
interface pswr_res_if;

    logic               valid;
    logic               ready;
    logic signed [31:0] top_value;
    logic               overflow;

    modport source (output valid, output top_value, output overflow, input ready);
    modport sink   (input valid, input top_value, input overflow, output ready);

endinterface

### hdl/pswr_dp.sv
// ---------------------------------------------------------------------------
// pswr_dp
// Datapath: node and version memories, top pointer, operation counter and
// the result registers.
// ---------------------------------------------------------------------------
module pswr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pswr_pkg::ctrl_cmd_t                 cmd,
    output pswr_pkg::dp_status_t                status,
    input  logic [1:0]                          operation,
    input  logic signed [pswr_pkg::FIELD_W-1:0] argument,
    output logic signed [pswr_pkg::FIELD_W-1:0] top_value,
    output logic                                overflow
);
    import pswr_pkg::*;

    logic [VALUE_BITS-1:0] node_value  [SLOTS];
    logic [IDX_W-1:0]      node_parent [SLOTS];
    logic [IDX_W-1:0]      version_top [SLOTS];

    logic [IDX_W-1:0]      top_reg;
    logic [IDX_W-1:0]      count_reg;
    logic                  empty_reg;
    logic                  ovf_reg;
    logic [IDX_W-1:0]      parent_rd_reg;
    logic [IDX_W-1:0]      vt_rd_reg;
    logic [VALUE_BITS-1:0] value_rd_reg;
    logic                  link_zero_reg;
    logic                  is_pop_reg;

    op_t                   op;
    logic [IDX_W-1:0]      seq;
    logic                  full;
    logic                  live;
    logic                  do_push;
    logic                  do_pop;
    logic                  do_rb;
    logic [30:0]           k;
    logic [IDX_W-1:0]      target;
    logic [IDX_W-1:0]      new_top;
    logic [VALUE_BITS-1:0] push_value;

    assign op         = op_t'(operation);
    assign seq        = count_reg + IDX_W'(1);
    assign full       = (count_reg == IDX_W'(MAX_OPS));
    assign live       = !full && (op != OP_NONE);
    assign do_push    = cmd.accept && live && (op == OP_PUSH);
    assign do_pop     = cmd.accept && live && (op == OP_POP);
    assign do_rb      = cmd.accept && live && (op == OP_ROLLBACK);
    assign push_value = fit_value(argument);

    // negative counts undo nothing; targets before the start clamp to version 0
    assign k      = argument[31] ? '0 : argument[30:0];
    assign target = (k < 31'(seq)) ? IDX_W'(31'(seq) - 31'd1 - k) : '0;

    // slot zero is the sentinel and is never written
    assign new_top = link_zero_reg ? '0 : (is_pop_reg ? parent_rd_reg : vt_rd_reg);

    assign status.needs_link = live && ((op == OP_POP) || (op == OP_ROLLBACK));

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            node_parent[seq] <= top_reg;
        end
        if (do_pop)
        begin
            parent_rd_reg <= node_parent[top_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            version_top[seq] <= seq;
        end
        else if (cmd.finish)
        begin
            version_top[seq] <= new_top;
        end
        if (do_rb)
        begin
            vt_rd_reg <= version_top[target];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            node_value[seq] <= push_value;
            value_rd_reg    <= push_value;
        end
        else if (cmd.finish)
        begin
            value_rd_reg <= node_value[new_top];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop || do_rb)
        begin
            link_zero_reg <= do_pop ? (top_reg == '0) : (target == '0);
            is_pop_reg    <= do_pop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg   <= '0;
            count_reg <= '0;
            empty_reg <= 1'b1;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.accept)
        begin
            ovf_reg <= (op != OP_NONE) && full;
            if (do_push)
            begin
                top_reg   <= seq;
                count_reg <= seq;
                empty_reg <= 1'b0;
            end
        end
        else if (cmd.finish)
        begin
            top_reg   <= new_top;
            count_reg <= seq;
            empty_reg <= (new_top == '0);
        end
    end

    assign top_value = empty_reg ? EMPTY_TOP : FIELD_W'(signed'(value_rd_reg));
    assign overflow  = ovf_reg;

endmodule

### hdl/pswr_ctrl.sv
// ---------------------------------------------------------------------------
// pswr_ctrl
// Controller: sequences the link read for pop and rollback and owns the
// handshake on both channels.
// ---------------------------------------------------------------------------
`include "persistent_stack_with_rollback_core_assert.svh"

module pswr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  res_valid,
    input  logic                  res_ready,
    input  pswr_pkg::dp_status_t  status,
    output pswr_pkg::ctrl_cmd_t   cmd
);
    import pswr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   accept;
    logic   produce;

    assign accept = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.needs_link)
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // take a new transaction while the result slot drains
                req_ready = !res_valid_reg || res_ready;
            end
            ST_LINK:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
        cmd.accept = accept;
        produce    = (accept && !status.needs_link) || cmd.finish;
        if (produce)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    `PSWR_ASSERT_NXT(a_link_entry, accept && status.needs_link, (state_reg == ST_LINK) && !res_valid_reg)
    `PSWR_ASSERT_NXT(a_link_result, state_reg == ST_LINK, res_valid_reg && (state_reg == ST_IDLE))
    `PSWR_ASSERT_NXT(a_direct_result, accept && !status.needs_link, res_valid_reg && (state_reg == ST_IDLE))

endmodule

### hdl/persistent_stack_with_rollback_core.sv
// Results: push, ignored code and refused operations show a result in the cycle after acceptance;
// pop and rollback first pass through the link state (a link read, then the node value read).
// Throughput: 1 operation per cycle for push while results are taken; pop and rollback hold off
// new operations through the dependent parent/version read and the value read that follows.
// Reset: asynchronous, empty stack and zero operations; memories are not cleared.
// ---------------------------------------------------------------------------
// persistent_stack_with_rollback_core
// Versioned stack with push, pop and rollback to an earlier version.
// ---------------------------------------------------------------------------
module persistent_stack_with_rollback_core (
    input  logic        clk,
    input  logic        rst_n,
    pswr_op_if.sink     op_stream,
    pswr_res_if.source  res_stream
);
    import pswr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pswr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (op_stream.valid),
        .req_ready (op_stream.ready),
        .res_valid (res_stream.valid),
        .res_ready (res_stream.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pswr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .operation (op_stream.operation),
        .argument  (op_stream.argument),
        .top_value (res_stream.top_value),
        .overflow  (res_stream.overflow)
    );

endmodule
